// ===== design/biq_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and the scale rounding table of the block-wise int4 quantiser
// no dependencies
package biq_pkg;

  localparam int unsigned MAX_BLOCK_DEF   = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned BLEN_W     = 7;
  localparam logic [BLEN_W-1:0] BLEN_RESET = 7'd32;
  localparam int unsigned CODE_W     = 4;
  localparam int unsigned SCALE_W    = 21;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned QUO_W      = 3;
  localparam logic [QUO_W:0] CODE_MAX = 4'd7;
  localparam logic [QUO_W:0] SCALE_DIV = 4'd7;

  // divider control, from the sequencer
  typedef struct packed {
    logic start;
    logic ack;
  } div_ctl_t;

  // divider status, to the sequencer
  typedef struct packed {
    logic                     done;
    logic signed [CODE_W-1:0] code;
  } div_stat_t;

  // round-to-nearest of b*256/7 for the remainder b of max/7
  function automatic logic [FRAC_W-1:0] scale_frac(input logic [QUO_W-1:0] rem);
    logic [FRAC_W-1:0] frac;
    unique case (rem)
      3'd0:    frac = 8'd0;
      3'd1:    frac = 8'd37;
      3'd2:    frac = 8'd73;
      3'd3:    frac = 8'd110;
      3'd4:    frac = 8'd146;
      3'd5:    frac = 8'd183;
      3'd6:    frac = 8'd219;
      default: frac = 8'd0;
    endcase
    return frac;
  endfunction

endpackage

// ===== design/biq_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for samples, results and the block length register
// uses biq_pkg for field widths
interface biq_smp_if #(
  parameter int unsigned SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface biq_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [biq_pkg::CODE_W-1:0]     code;
  logic        [biq_pkg::SCALE_W-1:0]    block_scale;
  logic                                  last_in_block;

  modport source (output valid, output code, output block_scale, output last_in_block,
                  input ready);
  modport sink   (input valid, input code, input block_scale, input last_in_block,
                  output ready);
endinterface

interface biq_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [biq_pkg::BLEN_W-1:0]    block_len;

  modport source (output valid, output block_len, input ready);
  modport sink   (input valid, input block_len, output ready);
endinterface

// ===== design/blockwise_int4_quantizer_unit.sv =====
`timescale 1ns / 1ps
// block-wise symmetric int4 quantiser: one sample word accepted per cycle while a block fills,
// then the scale is formed (max/7, one bit a cycle), a launch state starts the divider, and
// each code word is divided out by the serial divider (3 quotient bits plus rounding);
// the next code word is started only when the output register is free
// async active-low reset: block length 32, empty block, max zero; the sample store is not cleared
module blockwise_int4_quantizer_unit #(
  parameter int unsigned MAX_BLOCK   = biq_pkg::MAX_BLOCK_DEF,
  parameter int unsigned SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  biq_smp_if.sink  smp_i,
  biq_res_if.source res_o,
  biq_cfg_if.sink  cfg_i
);

  localparam int unsigned IW  = $clog2(MAX_BLOCK);       // store address
  localparam int unsigned FW  = $clog2(MAX_BLOCK + 1);   // fill count, holds MAX_BLOCK
  localparam int unsigned BCW = $clog2(SAMPLE_BITS);     // scale bit counter
  localparam int unsigned SCW = SAMPLE_BITS + biq_pkg::FRAC_W;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_SCALE,
    ST_LAUNCH,
    ST_EMIT
  } state_e;

  state_e                              state_q, state_d;
  logic [biq_pkg::BLEN_W-1:0]          blen_q, blen_d;
  logic [FW-1:0]                       fill_q, fill_d;
  logic [SAMPLE_BITS-1:0]              max_q, max_d;
  logic [SAMPLE_BITS-1:0]              shift_q, shift_d;    // max, then max/7
  logic [biq_pkg::QUO_W-1:0]           rem7_q, rem7_d;      // max % 7
  logic [BCW-1:0]                      bit_cnt_q, bit_cnt_d;
  logic [biq_pkg::SCALE_W-1:0]         scale_q, scale_d;
  logic [IW-1:0]                       idx_q, idx_d;
  logic [IW-1:0]                       rd_addr_q, rd_addr_d;
  logic                                out_valid_q, out_valid_d;
  logic signed [biq_pkg::CODE_W-1:0]   out_code_q, out_code_d;
  logic [biq_pkg::SCALE_W-1:0]         out_scale_q, out_scale_d;
  logic                                out_last_q, out_last_d;

  // sample store, read data registered
  logic signed [SAMPLE_BITS-1:0]       store_mem [MAX_BLOCK];
  logic signed [SAMPLE_BITS-1:0]       rd_data_q;
  logic                                wr_en;

  logic                                smp_acc;
  logic [SAMPLE_BITS-1:0]              mag_in;
  logic [SAMPLE_BITS-1:0]              max_new;
  logic [FW-1:0]                       fill_new;
  logic [FW-1:0]                       eff_len;
  logic [biq_pkg::QUO_W:0]             t7;
  logic                                ge7;
  logic [SCW+biq_pkg::SCALE_W-1:0]     scale_ext;
  logic                                is_last;
  logic                                out_free;
  biq_pkg::div_ctl_t                   div_ctl;
  biq_pkg::div_stat_t                  div_stat;

  assign smp_i.ready = (state_q == ST_COLLECT);
  assign smp_acc     = smp_i.valid && smp_i.ready;
  assign cfg_i.ready = 1'b1;

  assign res_o.valid         = out_valid_q;
  assign res_o.code          = out_code_q;
  assign res_o.block_scale   = out_scale_q;
  assign res_o.last_in_block = out_last_q;

  // effective block length: zero acts as one, saturates at the store depth
  always_comb begin
    if (blen_q == '0) begin
      eff_len = FW'(1);
    end else if (32'(blen_q) > 32'(MAX_BLOCK)) begin
      eff_len = FW'(MAX_BLOCK);
    end else begin
      eff_len = FW'(blen_q);
    end
  end

  assign mag_in   = smp_i.sample[SAMPLE_BITS-1] ? (~smp_i.sample + 1'b1) : smp_i.sample;
  assign max_new  = (mag_in > max_q) ? mag_in : max_q;
  assign fill_new = (32'(fill_q) < 32'(MAX_BLOCK)) ? (fill_q + 1'b1) : fill_q;

  // one quotient bit of max/7 per cycle
  assign t7  = {rem7_q, shift_q[SAMPLE_BITS-1]};
  assign ge7 = (t7 >= biq_pkg::SCALE_DIV);

  // scale = (max/7)*256 + round(rem*256/7); low byte is free so a concatenation does it
  assign scale_ext = {{biq_pkg::SCALE_W{1'b0}}, shift_q, biq_pkg::scale_frac(rem7_q)};

  assign is_last  = ({1'b0, idx_q} + 1'b1) == (IW + 1)'(fill_q);
  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d     = state_q;
    blen_d      = blen_q;
    fill_d      = fill_q;
    max_d       = max_q;
    shift_d     = shift_q;
    rem7_d      = rem7_q;
    bit_cnt_d   = bit_cnt_q;
    scale_d     = scale_q;
    idx_d       = idx_q;
    rd_addr_d   = rd_addr_q;
    out_valid_d = out_valid_q;
    out_code_d  = out_code_q;
    out_scale_d = out_scale_q;
    out_last_d  = out_last_q;
    wr_en       = 1'b0;
    div_ctl     = '0;

    if (cfg_i.valid && cfg_i.ready) begin
      blen_d = cfg_i.block_len;
    end
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_COLLECT: begin
        if (smp_acc) begin
          wr_en  = (32'(fill_q) < 32'(MAX_BLOCK));
          fill_d = fill_new;
          max_d  = max_new;
          // block complete: start the scale division
          if (fill_new >= eff_len) begin
            state_d   = ST_SCALE;
            shift_d   = max_new;
            rem7_d    = '0;
            bit_cnt_d = '0;
            rd_addr_d = '0;
          end
        end
      end
      ST_SCALE: begin
        rem7_d    = ge7 ? biq_pkg::QUO_W'(t7 - biq_pkg::SCALE_DIV)
                        : biq_pkg::QUO_W'(t7);
        shift_d   = {shift_q[SAMPLE_BITS-2:0], ge7};
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == BCW'(SAMPLE_BITS - 1)) begin
          state_d = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        // store word zero has been sitting in the read register since the scale began
        scale_d       = scale_ext[biq_pkg::SCALE_W-1:0];
        div_ctl.start = 1'b1;
        idx_d         = '0;
        rd_addr_d     = IW'(1);
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        if (div_stat.done && out_free) begin
          out_valid_d = 1'b1;
          out_code_d  = div_stat.code;
          out_scale_d = scale_q;
          out_last_d  = is_last;
          if (is_last) begin
            div_ctl.ack = 1'b1;
            fill_d      = '0;
            max_d       = '0;
            state_d     = ST_COLLECT;
          end else begin
            // next word was fetched during the last division
            div_ctl.start = 1'b1;
            idx_d         = idx_q + 1'b1;
            rd_addr_d     = rd_addr_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      blen_q      <= biq_pkg::BLEN_RESET;
      fill_q      <= '0;
      max_q       <= '0;
      shift_q     <= '0;
      rem7_q      <= '0;
      bit_cnt_q   <= '0;
      scale_q     <= '0;
      idx_q       <= '0;
      rd_addr_q   <= '0;
      out_valid_q <= 1'b0;
      out_code_q  <= '0;
      out_scale_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      blen_q      <= blen_d;
      fill_q      <= fill_d;
      max_q       <= max_d;
      shift_q     <= shift_d;
      rem7_q      <= rem7_d;
      bit_cnt_q   <= bit_cnt_d;
      scale_q     <= scale_d;
      idx_q       <= idx_d;
      rd_addr_q   <= rd_addr_d;
      out_valid_q <= out_valid_d;
      out_code_q  <= out_code_d;
      out_scale_q <= out_scale_d;
      out_last_q  <= out_last_d;
    end
  end

  // sample store: one write port while filling, one registered read port while emitting
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[fill_q[IW-1:0]] <= smp_i.sample;
    end
    rd_data_q <= store_mem[rd_addr_q];
  end

  biq_code_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_code_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (div_ctl),
    .sample_i (rd_data_q),
    .max_i    (max_q),
    .stat_o   (div_stat)
  );

endmodule

// ===== design/biq_code_div.sv =====
`timescale 1ns / 1ps
// restoring divider for one code: 7*|w| / max, one quotient bit per cycle, then round
// uses biq_pkg types and constants
module biq_code_div #(
  parameter int unsigned SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  biq_pkg::div_ctl_t             ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic        [SAMPLE_BITS-1:0] max_i,
  output biq_pkg::div_stat_t            stat_o
);

  localparam int unsigned NW = SAMPLE_BITS + 3;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [1:0]                    step_q, step_d;
  logic [NW-1:0]                 rem_q, rem_d;
  logic [NW-1:0]                 div_q, div_d;
  logic [biq_pkg::QUO_W-1:0]     quo_q, quo_d;
  logic                          neg_q, neg_d;
  logic [SAMPLE_BITS-1:0]        max_q, max_d;

  logic [SAMPLE_BITS-1:0]        mag;
  logic [NW-1:0]                 mag7;
  logic                          ge;
  logic [NW:0]                   two_r;
  logic [NW:0]                   m_ext;
  logic                          up;
  logic [biq_pkg::QUO_W:0]       q_rnd;
  logic [biq_pkg::QUO_W:0]       q_clip;
  logic signed [biq_pkg::CODE_W-1:0] code;

  assign mag  = sample_i[SAMPLE_BITS-1] ? (~sample_i + 1'b1) : sample_i;
  assign mag7 = {mag, 3'b000} - {3'b000, mag};
  assign ge   = (rem_q >= div_q);

  // round half to even on the final remainder
  assign two_r  = {rem_q, 1'b0};
  assign m_ext  = {{(NW + 1 - SAMPLE_BITS){1'b0}}, max_q};
  assign up     = (two_r > m_ext) || ((two_r == m_ext) && quo_q[0]);
  assign q_rnd  = {1'b0, quo_q} + {{biq_pkg::QUO_W{1'b0}}, up};
  assign q_clip = (q_rnd > biq_pkg::CODE_MAX) ? biq_pkg::CODE_MAX : q_rnd;

  always_comb begin
    if (max_q == '0) begin
      code = '0;
    end else if (neg_q) begin
      code = -$signed(q_clip);
    end else begin
      code = $signed(q_clip);
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.code = code;

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    max_d  = max_q;
    if (ctl_i.ack) begin
      done_d = 1'b0;
    end
    if (ctl_i.start) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = 2'd2;
      rem_d  = mag7;
      div_d  = {1'b0, max_i, 2'b00};
      quo_d  = '0;
      neg_d  = sample_i[SAMPLE_BITS-1];
      max_d  = max_i;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - div_q;
      end
      quo_d[step_q] = ge;
      div_d = {1'b0, div_q[NW-1:1]};
      if (step_q == 2'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      quo_q  <= '0;
      neg_q  <= 1'b0;
      max_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      rem_q  <= rem_d;
      div_q  <= div_d;
      quo_q  <= quo_d;
      neg_q  <= neg_d;
      max_q  <= max_d;
    end
  end

endmodule
